@@ rtl/mcad_pkg.sv @@
`default_nettype none
package mcad_pkg;

	localparam int CHANNELS    = 4;
	localparam int STORE_LEN   = 4096;
	localparam int SAMPLE_BITS = 32;

	localparam int NUM_DELAY_REGS = 4;
	localparam int DLY_FIELD_W    = 13;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int CH_W           = 2;
	localparam int WORD_W         = 32;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PTR_W    = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
	localparam int DLY_W    = $clog2(STORE_LEN + 1);
	localparam int DEPTH    = CHANNELS * STORE_LEN;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_CH0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = 3'd5;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_FILL,
		MODE_RING
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [ADDR_W-1:0] addr;
	} op_t;

endpackage
`default_nettype wire

@@ rtl/multichannel_audio_delay_line.sv @@
`default_nettype none
// Per-channel audio delay line. Each word on the slave side carries one raw sample
// tagged with its channel in tuser; the master side returns, in order, one word for
// each: the sample from delay_chN samples earlier on that channel, the silence value
// while the channel's store is still filling, or the sample itself when the channel's
// delay is zero or bypass is set. Writing a delay register restarts that channel's fill.
// Throughput is one word per clock while the master side is not stalled: every
// word makes at most one read-first access to the single-port sample store, and the
// per-channel fill counts and ring pointers are updated in the same cycle, so words
// of the same channel may follow back to back. A result is registered in stage one
// and then in the output register; a stalled master side holds both stages and then
// drops s_tready. The store needs no clearing pass after reset. Configuration is
// accepted at any time but should be written idle.
module multichannel_audio_delay_line (
	input  wire                            clk,
	input  wire                            arst_n,
	// slave: tdata = sample_in[31:0], tuser = channel[1:0], tlast = frame_last_in
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [mcad_pkg::WORD_W-1:0]     s_tdata,
	input  wire [mcad_pkg::CH_W-1:0]       s_tuser,
	input  wire                            s_tlast,
	// master: tdata = sample_out[31:0], tuser = channel_out[1:0], tlast = frame_last_out
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [mcad_pkg::WORD_W-1:0]    m_tdata,
	output logic [mcad_pkg::CH_W-1:0]      m_tuser,
	output logic                           m_tlast,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [mcad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [mcad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mcad_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	op_t                    op;
	logic [SAMPLE_BITS-1:0] silence;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   acc;
	logic                   s1_move;

	logic                   valid_s1;
	mode_t                  mode_s1;
	logic [CH_W-1:0]        ch_s1;
	logic                   last_s1;
	logic [SAMPLE_BITS-1:0] pre_s1;
	logic [SAMPLE_BITS-1:0] rd_s1;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic [CH_W-1:0]        out_ch_q;
	logic                   out_last_q;

	assign cfg_ready = 1'b1;
	assign sample    = SAMPLE_BITS'(s_tdata);
	assign s1_move   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || s1_move;
	assign acc       = s_tvalid && s_tready;

	mcad_chan_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (acc),
		.channel   (s_tuser),
		.op        (op),
		.silence   (silence)
	);

	// read-first: the ring read returns the old word while the new one replaces it
	always_ff @(posedge clk) begin
		if (acc && op.mode == MODE_RING) begin
			rd_s1 <= mem[op.addr];
		end
		if (acc && op.mode != MODE_PASS) begin
			mem[op.addr] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= op.mode;
			ch_s1   <= s_tuser;
			last_s1 <= s_tlast;
			pre_s1  <= (op.mode == MODE_FILL) ? silence : sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= (mode_s1 == MODE_RING) ? rd_s1 : pre_s1;
			out_ch_q   <= ch_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = WORD_W'(out_data_q);
	assign m_tuser  = out_ch_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word lost before stage one");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> (valid_s1 && $stable(pre_s1) && $stable(rd_s1)))
		else $error("stalled stage one word changed");
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are full");
`endif

endmodule
`default_nettype wire

@@ rtl/mcad_chan_state.sv @@
`default_nettype none
module mcad_chan_state (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [mcad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [mcad_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             req,
	input  wire [mcad_pkg::CH_W-1:0]        channel,
	output mcad_pkg::op_t                   op,
	output logic [mcad_pkg::SAMPLE_BITS-1:0] silence
);
	import mcad_pkg::*;

	logic [DLY_W-1:0] delay_q [NUM_DELAY_REGS];
	logic [DLY_W-1:0] fill_q  [CHANNELS];
	logic [PTR_W-1:0] ptr_q   [CHANNELS];
	logic             bypass_q;
	logic [SAMPLE_BITS-1:0] silence_q;

	logic                ch_ok;
	logic [CH_IDX_W-1:0] ch_idx;
	logic [DLY_W-1:0]    dly;
	logic [DLY_W-1:0]    fill;
	logic [PTR_W-1:0]    ptr;
	logic [PTR_W-1:0]    pos;
	logic [PTR_W-1:0]    ptr_nxt;
	logic [DLY_W-1:0]    dly_sat;
	mode_t               mode;
	logic [ADDR_W-1:0]   addr;

	assign ch_idx = CH_IDX_W'(channel);
	assign ch_ok  = 32'(channel) < 32'(CHANNELS);
	assign dly    = delay_q[channel];
	assign fill   = fill_q[ch_idx];
	assign ptr    = ptr_q[ch_idx];

	always_comb begin
		if (bypass_q || !ch_ok || dly == '0) begin
			mode = MODE_PASS;
		end else if (fill < dly) begin
			mode = MODE_FILL;
		end else begin
			mode = MODE_RING;
		end
	end

	// fill stays below the delay in the fill phase, so it fits a pointer
	assign pos     = (mode == MODE_FILL) ? PTR_W'(fill) : ptr;
	assign addr    = ADDR_W'(ch_idx) * ADDR_W'(STORE_LEN) + ADDR_W'(pos);
	assign op      = '{mode: mode, addr: addr};
	assign ptr_nxt = (DLY_W'(ptr) + DLY_W'(1) >= dly) ? '0 : ptr + PTR_W'(1);
	assign silence = silence_q;

	always_comb begin
		if (32'(cfg_data[DLY_FIELD_W-1:0]) > 32'(STORE_LEN)) begin
			dly_sat = DLY_W'(STORE_LEN);
		end else begin
			dly_sat = DLY_W'(cfg_data[DLY_FIELD_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q  <= 1'b0;
			silence_q <= '0;
			for (int i = 0; i < NUM_DELAY_REGS; i++) delay_q[i] <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
				ptr_q[i]  <= '0;
			end
		end else begin
			if (cfg_we && cfg_index == REG_SILENCE) begin
				silence_q <= SAMPLE_BITS'(cfg_data);
			end
			if (cfg_we && cfg_index == REG_BYPASS) begin
				bypass_q <= cfg_data[0];
			end
			for (int i = 0; i < NUM_DELAY_REGS; i++) begin
				if (cfg_we && cfg_index == REG_DELAY_CH0 + CFG_IDX_W'(i)) begin
					delay_q[i] <= dly_sat;
				end
			end
			for (int i = 0; i < CHANNELS; i++) begin
				if (cfg_we && i < NUM_DELAY_REGS &&
				    cfg_index == REG_DELAY_CH0 + CFG_IDX_W'(i)) begin
					// restart the channel: fill phase begins again
					fill_q[i] <= '0;
					ptr_q[i]  <= '0;
				end else if (req && ch_idx == CH_IDX_W'(i)) begin
					if (mode == MODE_FILL) begin
						fill_q[i] <= fill + DLY_W'(1);
					end else if (mode == MODE_RING) begin
						ptr_q[i] <= ptr_nxt;
					end
				end
			end
		end
	end

`ifndef SYNTH
	a_ring_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode == MODE_RING) |-> (DLY_W'(ptr) < dly))
		else $error("ring pointer at or beyond channel delay");
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= dly)
		else $error("fill count beyond channel delay");
	a_delay_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		dly <= DLY_W'(STORE_LEN))
		else $error("channel delay above store length");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
	import mcad_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned REPORT_LINES = 50;
	localparam int unsigned PHASE_WORDS = 75;
	localparam int unsigned WRAP_DELAY = 100;

	typedef struct {
		logic [CH_W-1:0]   ch;
		logic [WORD_W-1:0] data;
		logic              last;
	} audio_word_t;

	typedef struct {
		bit                   is_setting;
		logic [CFG_IDX_W-1:0] idx;
		logic [WORD_W-1:0]    data;
		logic [CH_W-1:0]      ch;
		logic                 last;
		bit                   typed;
		logic [WORD_W-1:0]    want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [WORD_W-1:0]     s_tdata = '0;
	logic [CH_W-1:0]       s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [WORD_W-1:0]     m_tdata;
	logic [CH_W-1:0]       m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// delay-line mirror
	logic [DLY_FIELD_W-1:0] delay_len [CHANNELS];
	logic [DLY_FIELD_W-1:0] fill_cnt [CHANNELS];
	logic [PTR_W-1:0]       ring_ptr [CHANNELS];
	logic [WORD_W-1:0]      delay_mem [DEPTH];
	logic [WORD_W-1:0]      silence_word = '0;
	logic                   bypass_on = 1'b0;

	audio_word_t pending_words [$];
	script_row_t directed_script [$];
	bit                typed_on = 1'b0;
	logic [WORD_W-1:0] typed_word = '0;
	bit                idle_on = 1'b1;
	int unsigned       fault_count = 0;
	int unsigned       quiet_cycles = 0;
	int unsigned       stall_left = 0;

	multichannel_audio_delay_line u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // sample_in[31:0]
		.s_tuser   (s_tuser),   // channel[1:0]
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // sample_out[31:0]
		.m_tuser   (m_tuser),   // channel_out[1:0]
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_delay();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 55) return $urandom_range(1, 8);
		if (r < 80) return $urandom_range(9, 64);
		if (r < 88) return STORE_LEN;
		if (r < 93) return STORE_LEN - 1;
		return $urandom();
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_silence();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 32'h0000_0080;
			2: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CFG_IDX_W-1:0] cfg_delay_idx(input int unsigned k);
		return REG_DELAY_CH0 + k[CFG_IDX_W-1:0];
	endfunction

	function automatic script_row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [WORD_W-1:0] data);
		script_row_t row;
		row = '{1'b1, idx, data, '0, 1'b0, 1'b0, '0};
		return row;
	endfunction

	function automatic script_row_t sample_row(input logic [CH_W-1:0] ch,
			input logic [WORD_W-1:0] data, input logic last, input bit typed,
			input logic [WORD_W-1:0] want);
		script_row_t row;
		row = '{1'b0, '0, data, ch, last, typed, want};
		return row;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		logic [DLY_FIELD_W-1:0] d;
		if (idx < REG_DELAY_CH0 + NUM_DELAY_REGS) begin
			d = data[DLY_FIELD_W-1:0];
			if (d > STORE_LEN)
				d = DLY_FIELD_W'(STORE_LEN);
			delay_len[idx - REG_DELAY_CH0] = d;
			// restart the channel's fill
			fill_cnt[idx - REG_DELAY_CH0] = '0;
			ring_ptr[idx - REG_DELAY_CH0] = '0;
		end else if (idx == REG_SILENCE) begin
			silence_word = data[WORD_W-1:0];
		end else if (idx == REG_BYPASS) begin
			bypass_on = data[0];
		end
	endfunction

	function automatic audio_word_t delayed_word(input logic [CH_W-1:0] ch,
			input logic [WORD_W-1:0] sample, input logic last);
		audio_word_t w;
		int unsigned slot;
		logic [DLY_FIELD_W-1:0] nxt;
		w.ch = ch;
		w.data = sample;
		w.last = last;
		if (!bypass_on && delay_len[ch] != 0) begin
			if (fill_cnt[ch] < delay_len[ch]) begin
				slot = ch * STORE_LEN + fill_cnt[ch];
				delay_mem[slot] = sample;
				fill_cnt[ch] = fill_cnt[ch] + 1'b1;
				w.data = silence_word;
			end else begin
				slot = ch * STORE_LEN + ring_ptr[ch];
				w.data = delay_mem[slot];
				delay_mem[slot] = sample;
				nxt = ring_ptr[ch] + 1'b1;
				if (nxt >= delay_len[ch])
					nxt = '0;
				ring_ptr[ch] = nxt[PTR_W-1:0];
			end
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		fault_count++;
		if (fault_count <= REPORT_LINES)
			$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
	endtask

	// all tasks below are entered and left at a falling edge
	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_sample(input logic [CH_W-1:0] ch, input logic [WORD_W-1:0] data,
			input logic last, input bit typed, input logic [WORD_W-1:0] want);
		int unsigned gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = ch;
		s_tdata = data;
		s_tlast = last;
		typed_on = typed;
		typed_word = want;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_words(input int unsigned settle);
		s_tvalid = 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (stall_left != 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			if (idle_on)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		audio_word_t w;
		audio_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				w = delayed_word(s_tuser, s_tdata, s_tlast);
				if (typed_on)
					w.data = typed_word;
				pending_words.push_back(w);
			end
			if (m_tvalid && m_tready) begin
				if (pending_words.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 'x);
				end else begin
					want = pending_words.pop_front();
					if (m_tuser !== want.ch)
						report_mismatch("channel", m_tuser, want.ch);
					if (m_tdata !== want.data)
						report_mismatch("sample", m_tdata, want.data);
					if (m_tlast !== want.last)
						report_mismatch("frame marker", m_tlast, want.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned n;
		int unsigned k;
		int unsigned hold_at;
		int unsigned ch0_sent;
		logic [CH_W-1:0] ch;

		for (k = 0; k < CHANNELS; k++) begin
			delay_len[k] = '0;
			fill_cnt[k] = '0;
			ring_ptr[k] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pass-through after reset, fill and ring with short delays, bypass,
		// saturation and masking of register writes, unused register indexes
		directed_script.push_back(sample_row(2'd0, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF));
		directed_script.push_back(sample_row(2'd3, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000));
		directed_script.push_back(sample_row(2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(setting_row(REG_SILENCE, 32'h0000_0080));
		directed_script.push_back(setting_row(cfg_delay_idx(0), 32'd2));
		directed_script.push_back(setting_row(cfg_delay_idx(1), 32'd1));
		directed_script.push_back(sample_row(2'd0, 32'h1111_1111, 1'b0, 1'b1, 32'h0000_0080));
		directed_script.push_back(sample_row(2'd1, 32'h2222_2222, 1'b0, 1'b1, 32'h0000_0080));
		directed_script.push_back(sample_row(2'd1, 32'h3333_3333, 1'b1, 1'b1, 32'h2222_2222));
		directed_script.push_back(sample_row(2'd0, 32'h4444_4444, 1'b0, 1'b1, 32'h0000_0080));
		directed_script.push_back(sample_row(2'd0, 32'h5555_5555, 1'b0, 1'b1, 32'h1111_1111));
		directed_script.push_back(sample_row(2'd0, 32'h6666_6666, 1'b0, 1'b1, 32'h4444_4444));
		directed_script.push_back(sample_row(2'd0, 32'h7777_7777, 1'b1, 1'b1, 32'h5555_5555));
		directed_script.push_back(setting_row(REG_BYPASS, 32'd1));
		directed_script.push_back(sample_row(2'd0, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'hA5A5_A5A5));
		directed_script.push_back(sample_row(2'd1, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'h5A5A_5A5A));
		directed_script.push_back(setting_row(REG_BYPASS, 32'hFFFF_FFFE));
		directed_script.push_back(sample_row(2'd0, 32'h8888_8888, 1'b0, 1'b0, '0));
		directed_script.push_back(setting_row(REG_SILENCE, 32'hFFFF_FFFF));
		directed_script.push_back(setting_row(cfg_delay_idx(0), 32'hFFFF_1FFF));
		directed_script.push_back(sample_row(2'd0, 32'h0123_4567, 1'b1, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(setting_row(cfg_delay_idx(0), 32'h0000_2003));
		directed_script.push_back(sample_row(2'd0, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(setting_row(REG_UNUSED_LO, 32'hFFFF_FFFF));
		directed_script.push_back(setting_row(REG_UNUSED_HI, 32'h0000_0000));
		directed_script.push_back(sample_row(2'd0, 32'hFEDC_BA98, 1'b0, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(sample_row(2'd0, 32'h7654_3210, 1'b1, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(sample_row(2'd0, 32'hC3C3_C3C3, 1'b0, 1'b0, '0));
		directed_script.push_back(setting_row(cfg_delay_idx(3), STORE_LEN));
		directed_script.push_back(setting_row(cfg_delay_idx(2), STORE_LEN - 1));
		directed_script.push_back(sample_row(2'd3, 32'h8000_0001, 1'b1, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(sample_row(2'd2, 32'h0F0F_0F0F, 1'b0, 1'b1, 32'hFFFF_FFFF));
		directed_script.push_back(sample_row(2'd1, 32'hF0F0_F0F0, 1'b1, 1'b0, '0));

		foreach (directed_script[i]) begin
			if (directed_script[i].is_setting) begin
				drain_words(3);
				write_setting(directed_script[i].idx, directed_script[i].data);
			end else begin
				send_sample(directed_script[i].ch, directed_script[i].data,
					directed_script[i].last, directed_script[i].typed, directed_script[i].want);
			end
		end

		for (phase = 0; phase < 6; phase++) begin
			drain_words(3);
			idle_on = (phase != 1);
			for (k = 0; k < NUM_DELAY_REGS; k++)
				write_setting(cfg_delay_idx(k), pick_delay());
			write_setting(REG_SILENCE, pick_silence());
			write_setting(REG_BYPASS, (phase == 3) ? ($urandom() | 32'd1) : ($urandom() & ~32'd1));
			write_setting(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom());
			hold_at = $urandom_range(20, 60);
			for (n = 0; n < PHASE_WORDS; n++) begin
				// hold the sender until every pending word is out
				if (n == hold_at)
					drain_words(0);
				send_sample(CH_W'($urandom_range(0, CHANNELS - 1)), $urandom(),
					1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		// run one store through fill and past its wrap, other channels interleaved
		drain_words(3);
		idle_on = 1'b1;
		write_setting(cfg_delay_idx(0), WRAP_DELAY);
		write_setting(cfg_delay_idx(1), 32'd64);
		write_setting(cfg_delay_idx(2), 32'd1);
		write_setting(cfg_delay_idx(3), 32'd0);
		write_setting(REG_SILENCE, $urandom());
		write_setting(REG_BYPASS, 32'd0);
		ch0_sent = 0;
		while (ch0_sent < WRAP_DELAY + 30) begin
			ch = ($urandom_range(0, 9) < 8) ? 2'd0 : CH_W'($urandom_range(1, CHANNELS - 1));
			if (ch == 0)
				ch0_sent++;
			send_sample(ch, $urandom(), 1'($urandom_range(0, 1)), 1'b0, '0);
		end

		drain_words(8);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/mcad_pkg.sv
rtl/mcad_chan_state.sv
rtl/multichannel_audio_delay_line.sv
tb/testbench.sv
